/* design/sliding_window_k_smallest_sum_min_macros.svh */
// Assertion macros shared by the sliding window k-smallest sum design.
`ifndef SLIDING_WINDOW_K_SMALLEST_SUM_MIN_MACROS_SVH
`define SLIDING_WINDOW_K_SMALLEST_SUM_MIN_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SWKSM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SWKSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/swksm_pkg.sv */
// Package with widths, register codes, state and interface types for the window sum block.
package swksm_pkg;

	localparam int MAX_WINDOW_DEF = 64;

	localparam int VALUE_W = 32;
	localparam int SUM_W   = 39;
	localparam int PICK_W  = 7;
	localparam int SPAN_W  = 6;
	localparam int COUNT_W = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;
	localparam logic [PICK_W-1:0]  PICK_RESET = 7'd3;
	localparam logic [SPAN_W-1:0]  SPAN_RESET = 6'd1;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic [0:0] {
		REG_PICK_COUNT = 1'b0,
		REG_SPAN       = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PICK_W-1:0] pick_count;
		logic [SPAN_W-1:0] span;
		logic              restart;
	} cfg_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [SUM_W-1:0] a;
		logic [SUM_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             lt;
		logic             eq;
	} alu_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OLD,
		S_SRCH,
		S_DN,
		S_UP,
		S_UPD,
		S_SUM,
		S_BEST,
		S_OUT
	} state_t;

endpackage

/* design/swksm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module swksm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/swksm_alu.sv */
// Shared adder and magnitude comparator used by the search, walk, sum, best and output steps of the sequencer.
module swksm_alu
	import swksm_pkg::*;
(
	input  alu_req_t req,
	output alu_res_t res
);

	logic             sub;
	logic [SUM_W:0]   r;

	assign sub = (req.op == ALU_SUB);

	// A subtract is an add of the inverted operand plus one; the carry out says a >= b.
	assign r = {1'b0, req.a} + {1'b0, (sub ? ~req.b : req.b)} + (SUM_W + 1)'(sub);

	assign res.sum = r[SUM_W-1:0];
	assign res.lt  = sub & ~r[SUM_W];
	assign res.eq  = sub & (r[SUM_W-1:0] == '0);

endmodule

/* design/swksm_cfg.sv */
// Register file for pick count and span behind an APB-style port.
module swksm_cfg
	import swksm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic              wr;
	reg_idx_t          idx;
	logic [PICK_W-1:0] pick_q;
	logic [SPAN_W-1:0] span_q;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_q <= PICK_RESET;
			span_q <= SPAN_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_PICK_COUNT: pick_q <= pwdata[PICK_W-1:0];
				REG_SPAN:       span_q <= pwdata[SPAN_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PICK_COUNT: prdata = APB_DW'(pick_q);
			REG_SPAN:       prdata = APB_DW'(span_q);
			default:        prdata = '0;
		endcase
	end

	// Any register write starts a new sequence.
	assign cfg.pick_count = pick_q;
	assign cfg.span       = span_q;
	assign cfg.restart    = wr;

endmodule

/* design/swksm_core.sv */
// Sequencer, window stores and result register of the window sum block.
`include "sliding_window_k_smallest_sum_min_macros.svh"
module swksm_core
	import swksm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic [VALUE_W-1:0] value,
	input  logic               last,
	input  logic               item_valid,
	output logic               item_ready,
	output logic [SUM_W-1:0]   min_cost,
	output logic               too_short,
	output logic               result_valid,
	input  logic               result_ready
);

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int WC_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	state_t             state_q, state_d;
	logic [VALUE_W-1:0] head_q;
	logic [SUM_W-1:0]   best_q;
	logic [COUNT_W-1:0] items_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   win_q;
	logic               res_valid_q;

	logic [VALUE_W-1:0] v_q;
	logic               last_q;
	logic               head_item_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   take_q;
	logic [VALUE_W-1:0] old_q;
	logic [IDX_W-1:0]   pos_q;
	logic [CNT_W-1:0]   ra_q;
	logic               moved_q;
	logic               repl_q;
	logic [SUM_W-1:0]   acc_q;
	logic [SUM_W-1:0]   min_cost_q;
	logic               too_short_q;

	logic [WC_W-1:0]    span_ext;
	logic [CNT_W-1:0]   win_c;
	logic [PICK_W-1:0]  need_c;
	logic [COUNT_W-1:0] after_c;
	logic [CNT_W-1:0]   fill_c;
	logic               is_head;
	logic [CNT_W-1:0]   fill_n;
	logic [CNT_W-1:0]   take_n;
	logic               do_sum;
	logic [IDX_W-1:0]   ptr_n;
	logic [IDX_W-1:0]   idx_prev;
	logic               found;
	logic               srch_end;
	logic               dn_move;
	logic               up_move;
	logic               out_load;

	logic               srt_we;
	logic [IDX_W-1:0]   srt_waddr;
	logic [VALUE_W-1:0] srt_wdata;
	logic [IDX_W-1:0]   srt_raddr;
	logic [VALUE_W-1:0] srt_rdata;
	logic               ring_we;
	logic [VALUE_W-1:0] ring_rdata;

	alu_req_t           alu_req;
	alu_res_t           alu_res;

	swksm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_WINDOW)
	) u_sorted (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (srt_wdata),
		.raddr (srt_raddr),
		.rdata (srt_rdata)
	);

	swksm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ptr_q),
		.wdata (v_q),
		.raddr (ptr_q),
		.rdata (ring_rdata)
	);

	swksm_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// Window size, needed count and current fill of the window.
	assign span_ext = WC_W'(cfg.span) + WC_W'(1);
	assign win_c    = (span_ext > WC_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(span_ext);
	assign need_c   = (cfg.pick_count != '0) ? cfg.pick_count - PICK_W'(1) : '0;
	assign after_c  = items_q - COUNT_W'(1);
	assign fill_c   = (WC_W'(after_c) < WC_W'(win_c)) ? CNT_W'(after_c) : win_c;
	assign is_head  = (items_q == '0);

	assign fill_n   = head_item_q ? '0 : ((fill_q == win_q) ? win_q : fill_q + CNT_W'(1));
	assign take_n   = (WC_W'(need_c) < WC_W'(fill_n)) ? CNT_W'(need_c) : fill_n;
	assign do_sum   = (fill_n == win_q) || last_q;
	assign ptr_n    = ((CNT_W'(ptr_q) + CNT_W'(1)) >= win_q) ? '0 : ptr_q + IDX_W'(1);

	assign idx_prev = ra_q[IDX_W-1:0] - IDX_W'(1);
	assign found    = alu_res.eq;
	assign srch_end = (ra_q == win_q);
	assign dn_move  = (pos_q != '0) && alu_res.lt;
	assign up_move  = ((CNT_W'(pos_q) + CNT_W'(1)) < win_q) && alu_res.lt;
	assign out_load = (state_q == S_OUT) && (!res_valid_q || result_ready);

	// Operand selection for the shared unit.
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = acc_q;
		alu_req.b  = SUM_W'(srt_rdata);
		unique case (state_q)
			S_SRCH: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = SUM_W'(srt_rdata);
				alu_req.b  = SUM_W'(old_q);
			end
			S_DN: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = SUM_W'(v_q);
				alu_req.b  = SUM_W'(srt_rdata);
			end
			S_UP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = SUM_W'(srt_rdata);
				alu_req.b  = SUM_W'(v_q);
			end
			S_BEST: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = acc_q;
				alu_req.b  = best_q;
			end
			S_OUT: begin
				alu_req.a  = SUM_W'(head_q);
				alu_req.b  = best_q;
			end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (is_head) begin
						state_d = last ? S_UPD : S_IDLE;
					end else begin
						state_d = (fill_c == win_c) ? S_OLD : S_DN;
					end
				end
			end
			S_OLD:  state_d = S_SRCH;
			S_SRCH: begin
				if (found || srch_end) begin
					state_d = S_DN;
				end
			end
			S_DN: begin
				if (dn_move) begin
					state_d = S_DN;
				end else if (repl_q && !moved_q) begin
					state_d = S_UP;
				end else begin
					state_d = S_UPD;
				end
			end
			S_UP:   state_d = up_move ? S_UP : S_UPD;
			S_UPD: begin
				if (!do_sum) begin
					state_d = S_IDLE;
				end else if (take_n == '0) begin
					state_d = S_BEST;
				end else begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (ra_q == take_q) begin
					state_d = S_BEST;
				end
			end
			S_BEST: state_d = last_q ? S_OUT : S_IDLE;
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory controls.
	always_comb begin
		item_ready = 1'b0;
		srt_we     = 1'b0;
		srt_waddr  = pos_q;
		srt_wdata  = v_q;
		srt_raddr  = '0;
		ring_we    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				srt_raddr  = fill_c[IDX_W-1:0] - IDX_W'(1);
			end
			S_SRCH: srt_raddr = found ? idx_prev - IDX_W'(1) : ra_q[IDX_W-1:0];
			S_DN: begin
				if (dn_move) begin
					srt_we    = 1'b1;
					srt_wdata = srt_rdata;
					srt_raddr = pos_q - IDX_W'(2);
				end else if (repl_q && !moved_q) begin
					srt_raddr = pos_q + IDX_W'(1);
				end else begin
					srt_we    = 1'b1;
				end
			end
			S_UP: begin
				srt_we = 1'b1;
				if (up_move) begin
					srt_wdata = srt_rdata;
					srt_raddr = pos_q + IDX_W'(2);
				end
			end
			S_UPD:  ring_we   = !head_item_q;
			S_SUM:  srt_raddr = ra_q[IDX_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			best_q      <= '1;
			items_q     <= '0;
			ptr_q       <= '0;
			win_q       <= CNT_W'(1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						win_q <= win_c;
						if (is_head) begin
							head_q  <= value;
							items_q <= COUNT_W'(1);
							best_q  <= '1;
							ptr_q   <= '0;
						end
					end
				end
				S_UPD: begin
					if (!head_item_q) begin
						ptr_q <= ptr_n;
						if (items_q < COUNT_MAX) begin
							items_q <= items_q + COUNT_W'(1);
						end
					end
				end
				S_BEST: begin
					if (alu_res.lt) begin
						best_q <= acc_q;
					end
				end
				S_OUT: begin
					if (out_load) begin
						items_q <= '0;
						best_q  <= '1;
						ptr_q   <= '0;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.restart) begin
				items_q <= '0;
				best_q  <= '1;
				ptr_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					v_q         <= value;
					last_q      <= last;
					head_item_q <= is_head;
					fill_q      <= fill_c;
					pos_q       <= fill_c[IDX_W-1:0];
					moved_q     <= 1'b0;
					repl_q      <= (fill_c == win_c);
				end
			end
			S_OLD: begin
				old_q <= ring_rdata;
				ra_q  <= CNT_W'(1);
			end
			S_SRCH: begin
				if (found) begin
					pos_q <= idx_prev;
				end else if (srch_end) begin
					pos_q <= '0;
				end else begin
					ra_q <= ra_q + CNT_W'(1);
				end
			end
			S_DN: begin
				if (dn_move) begin
					pos_q   <= pos_q - IDX_W'(1);
					moved_q <= 1'b1;
				end
			end
			S_UP: begin
				if (up_move) begin
					pos_q <= pos_q + IDX_W'(1);
				end
			end
			S_UPD: begin
				take_q <= take_n;
				acc_q  <= '0;
				ra_q   <= CNT_W'(1);
			end
			S_SUM: begin
				acc_q <= alu_res.sum;
				if (ra_q != take_q) begin
					ra_q <= ra_q + CNT_W'(1);
				end
			end
			S_OUT: begin
				if (out_load) begin
					min_cost_q  <= alu_res.sum;
					too_short_q <= (after_c < need_c);
				end
			end
			default: ;
		endcase
	end

	assign min_cost     = min_cost_q;
	assign too_short    = too_short_q;
	assign result_valid = res_valid_q;

	`SWKSM_ASSERT_IMPL(a_ptr_in_window, items_q != '0, CNT_W'(ptr_q) < win_q, "ring pointer outside the window")
	`SWKSM_ASSERT_IMPL(a_search_bound, state_q == S_SRCH, ra_q <= win_q, "search ran past the window")
	`SWKSM_ASSERT_IMPL(a_walk_bound, state_q == S_DN || state_q == S_UP, CNT_W'(pos_q) < win_q, "walk position outside the window")
	`SWKSM_ASSERT_NEXT(a_out_hold, state_q == S_OUT && res_valid_q && !result_ready, state_q == S_OUT, "result overwritten while still pending")

endmodule

/* design/sliding_window_k_smallest_sum_min.sv */
// Top level of the sliding window sum of the k smallest values, with head value.
//
// The block takes a sequence of unsigned 32-bit values, one per input transaction, with last
// marking the final one. The first value of a sequence is the head. Every later value enters a
// window of W = min(span+1, MAX_WINDOW) values, kept twice: in arrival order in a ring RAM and
// ascending in a sorted RAM. Each time the window is full the block sums its pick_count-1
// smallest entries and keeps the least such sum; on the last value it returns one result
// transaction with min_cost = head + least sum (the single partial window is used if the
// window never filled) and too_short set when fewer than pick_count-1 values followed the
// head. All value arithmetic and compares go through one shared 39-bit adder, stepped by a
// small sequencer, and both window stores are single-port-read RAMs with registered read
// data. A head value is only captured, and if it is also last it then passes through the
// update, best and output steps. A later value first walks from the back of the sorted
// store toward the front past every larger entry, and the update step then writes it into
// the ring. Once the window is full, the oldest value is first read from the ring and
// searched for in the sorted store, and the new value then walks from that slot toward the
// front or toward the back. A sum is formed when the value completes a window or is last:
// the smallest entries are read and added in turn, and the sum is then compared with the
// least one so far. A last value then passes through the output stage. The input side is
// not ready while a value is being worked on, but a finished result waits in its own
// output register, so the next sequence can start while the previous result has not yet been
// taken. Writing either register through the APB-style port (pick_count at 0x0, span at
// 0x4) abandons the sequence in progress, and the next value is a head. There is no clearing
// pass after reset: the window stores are never read before being written within a sequence.
module sliding_window_k_smallest_sum_min
	import swksm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,

	// Input channel: one sequence value per transaction.
	input  logic [VALUE_W-1:0] value,
	input  logic               last,
	input  logic               item_valid,
	output logic               item_ready,

	// Result channel: one transaction per sequence.
	output logic [SUM_W-1:0]   min_cost,
	output logic               too_short,
	output logic               result_valid,
	input  logic               result_ready
);

	// Register values and the restart pulse that a write produces.
	cfg_t cfg;

	swksm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer owns both window RAMs, the shared adder and the result register.
	swksm_core #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.value        (value),
		.last         (last),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.min_cost     (min_cost),
		.too_short    (too_short),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

/* sim/tb.sv */
// Self-checking testbench for the sliding window sum of the k smallest values.

module tb
	import swksm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Wait after the last expected result before a register write or the end of the run.
	// A value without last returns nothing, and a full 64-entry window with a large pick
	// count is the slowest case for the block, which this wait is meant to cover with a margin.
	localparam int SETTLE_CYCLES = 256;

	// The slowest correct run is far below this limit. That run would have about 1400
	// transactions, the longest sender gaps and receiver stalls, and a settle wait per register write.
	localparam int CYCLE_LIMIT = 2_000_000;

	// One expected result transaction.
	typedef struct packed {
		logic [SUM_W-1:0] min_cost;
		logic             too_short;
	} cost_t;

	// A row of the directed table is either an input transaction or a register write.
	typedef enum logic {
		ROW_ITEM,
		ROW_WRITE
	} row_kind_t;

	// For an item row, data is the value. For a write row, data is the register value.
	// Where typed is set, the result is given as a literal instead of by the predictor.
	typedef struct packed {
		row_kind_t         kind;
		reg_idx_t          reg_sel;
		logic [VALUE_W-1:0] data;
		logic              last;
		logic              typed;
		cost_t             lit;
	} row_t;

	// One random phase: a register setting, idle rates on both sides and an item budget.
	typedef struct packed {
		logic [PICK_W-1:0] pick;
		logic [SPAN_W-1:0] span;
		logic [6:0]        gap_pct;
		logic [6:0]        stall_pct;
		logic [15:0]       items;
	} phase_t;

	// Directed part. After reset, pick_count is 3 and span is 1, so the window holds two values
	// and the two smallest are summed.
	localparam int SCRIPT_LEN = 30;
	localparam row_t SCRIPT [SCRIPT_LEN] = '{
		// A head alone costs the head. Nothing followed it, so the sequence is too short.
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd7,          1'b1, 1'b1, '{39'd7, 1'b1}},
		// All ones everywhere: the widest sum is three times the largest value.
		'{ROW_ITEM,  REG_PICK_COUNT, 32'hFFFF_FFFF,  1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'hFFFF_FFFF,  1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'hFFFF_FFFF,  1'b1, 1'b1, '{39'h2_FFFF_FFFD, 1'b0}},
		// All zeros, one value short of a full window: the partial window is used.
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd0,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd0,          1'b1, 1'b1, '{39'd0, 1'b1}},
		// A pick count of one sums no values.
		'{ROW_WRITE, REG_PICK_COUNT, 32'd1,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd5,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd9,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd3,          1'b1, 1'b1, '{39'd5, 1'b0}},
		// A pick count of zero sums no values either.
		'{ROW_WRITE, REG_PICK_COUNT, 32'd0,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd11,         1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd2,          1'b1, 1'b1, '{39'd11, 1'b0}},
		// The pick count is above a three-value window, so whole windows are summed.
		// The first window gives 60, the second 90. With only four values after the
		// head, the sequence is too short for a pick count of 64.
		'{ROW_WRITE, REG_PICK_COUNT, 32'd64,         1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_WRITE, REG_SPAN,       32'd2,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd1,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd10,         1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd20,         1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd30,         1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd40,         1'b1, 1'b1, '{39'd61, 1'b1}},
		// A sequence left open is dropped by the register writes that follow it.
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd100,        1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd1,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_WRITE, REG_PICK_COUNT, 32'd3,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_WRITE, REG_SPAN,       32'd63,         1'b0, 1'b0, '{39'd0, 1'b0}},
		// The widest window, far from full: head 2 plus the partial sum 3 + 4.
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd2,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd3,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd4,          1'b1, 1'b1, '{39'd9, 1'b0}},
		// Extremes mixed in one sequence are left to the predictor.
		'{ROW_ITEM,  REG_PICK_COUNT, 32'hFFFF_FFFF,  1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'd0,          1'b0, 1'b0, '{39'd0, 1'b0}},
		'{ROW_ITEM,  REG_PICK_COUNT, 32'hFFFF_FFFF,  1'b1, 1'b0, '{39'd0, 1'b0}}
	};

	// Random phases. Most use small windows, and a few use the widest window, since a full
	// 64-entry window is the slow case. The idle rates cover four cases: no idling, a mostly
	// idle sender, a mostly stalling receiver, and both sides idling now and then.
	localparam int PHASE_COUNT = 9;
	localparam phase_t PHASES [PHASE_COUNT] = '{
		'{7'd3,  6'd1,  7'd0,  7'd0,  16'd240},
		'{7'd2,  6'd63, 7'd77, 7'd0,  16'd110},
		'{7'd64, 6'd63, 7'd0,  7'd77, 16'd70},
		'{7'd5,  6'd7,  7'd26, 7'd26, 16'd240},
		'{7'd64, 6'd3,  7'd0,  7'd0,  16'd180},
		'{7'd2,  6'd1,  7'd77, 7'd0,  16'd180},
		'{7'd10, 6'd20, 7'd26, 7'd26, 16'd150},
		'{7'd1,  6'd5,  7'd0,  7'd77, 16'd120},
		'{7'd33, 6'd40, 7'd0,  7'd0,  16'd90}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic [VALUE_W-1:0] value = '0;
	logic               last = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [SUM_W-1:0]   min_cost;
	logic               too_short;
	logic               result_valid;
	logic               result_ready = 1'b0;

	// Idle rates in percent. The main process sets them for each phase.
	int gap_pct = 0;
	int stall_pct = 0;

	int mismatch_count = 0;
	int cycle_count = 0;

	// Results still owed by the block, oldest first.
	cost_t expected_costs[$];
	cost_t oldest_cost;

	// The predictor's own copy of the registers and of the sequence in progress. Only the
	// values of the current window are kept, in arrival order. The sum of the smallest ones
	// is worked out afresh from them each time it is needed.
	logic [PICK_W-1:0]  pick_q;
	logic [SPAN_W-1:0]  span_q;
	logic [VALUE_W-1:0] head_q;
	logic [SUM_W-1:0]   best_q;
	logic [COUNT_W-1:0] seen_q;
	logic [VALUE_W-1:0] window_vals[$];

	sliding_window_k_smallest_sum_min dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.value        (value),
		.last         (last),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.min_cost     (min_cost),
		.too_short    (too_short),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sum of the take smallest values in the current window. Sorts a copy of the window by
	// insertion. Equal values are kept, so duplicates count once each.
	function automatic logic [SUM_W-1:0] sum_of_smallest(input int unsigned take);
		logic [VALUE_W-1:0] sorted_vals[MAX_WINDOW_DEF];
		logic [VALUE_W-1:0] v;
		logic [SUM_W-1:0]   acc;
		int                 n;
		int                 j;
		n = window_vals.size();
		acc = '0;
		if (take > n)
			take = n;
		for (int i = 0; i < n; i++) begin
			v = window_vals[i];
			j = i;
			while (j > 0 && sorted_vals[j-1] > v) begin
				sorted_vals[j] = sorted_vals[j-1];
				j--;
			end
			sorted_vals[j] = v;
		end
		for (int i = 0; i < take; i++)
			acc += SUM_W'(sorted_vals[i]);
		return acc;
	endfunction

	// Advances the predictor by one accepted input transaction. When the value closes a
	// sequence, done is set and the result is returned.
	task automatic advance_cost_model(input logic [VALUE_W-1:0] v, input logic l,
			output bit done, output cost_t res);
		int unsigned      w;
		int unsigned      need;
		int unsigned      after;
		logic [SUM_W-1:0] s;
		w = int'(span_q) + 1;
		if (w > MAX_WINDOW_DEF)
			w = MAX_WINDOW_DEF;
		need = (pick_q >= 1) ? int'(pick_q) - 1 : 0;
		done = 1'b0;
		res = '0;
		if (seen_q == 0) begin
			// The first value of a sequence is the head. It never enters the window.
			head_q = v;
			seen_q = COUNT_W'(1);
			best_q = '1;
			window_vals.delete();
		end else begin
			window_vals.push_back(v);
			if (window_vals.size() > w)
				window_vals.delete(0);
			if (seen_q < COUNT_MAX)
				seen_q++;
			if (window_vals.size() == w) begin
				s = sum_of_smallest(need);
				if (s < best_q)
					best_q = s;
			end
		end
		if (l) begin
			after = int'(seen_q) - 1;
			// A window that never filled is used once, as it stands.
			if (window_vals.size() < w) begin
				s = sum_of_smallest(need);
				if (s < best_q)
					best_q = s;
			end
			res.min_cost = SUM_W'(head_q) + best_q;
			res.too_short = (after < need);
			done = 1'b1;
			seen_q = '0;
		end
	endtask

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h, cycle %0d", what, got, want,
			cycle_count);
		mismatch_count++;
	endtask

	// Sends one value. The sender may first sit idle. Valid then stays high with the
	// payload held until the transaction is taken. The predictor steps once it is taken.
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic l, input logic typed,
			input cost_t lit);
		bit    done;
		cost_t res;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		item_valid <= 1'b1;
		value <= v;
		last <= l;
		do
			@(posedge clk);
		while (!item_ready);
		advance_cost_model(v, l, done, res);
		if (done)
			expected_costs.push_back(typed ? lit : res);
	endtask

	// Holds the sender back until every owed result is in. Then it waits out any work that
	// is still running on values that return nothing.
	task automatic wait_idle();
		while (expected_costs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A write has a setup phase and an access phase. The register takes the value at the edge
	// where the access phase meets pready. The sequence in progress is dropped.
	task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(int'(idx) * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PICK_COUNT: pick_q = data[PICK_W-1:0];
			REG_SPAN:       span_q = data[SPAN_W-1:0];
			default: ;
		endcase
		seen_q = '0;
	endtask

	// The receiver is ready at random, at the rate the current phase sets.
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= stall_pct);

	// Checks each result transaction against the oldest one owed. Outputs are read at the
	// edge, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_costs.size() == 0) begin
				report_mismatch("result with none owed", {25'b0, min_cost}, 64'd0);
			end else begin
				oldest_cost = expected_costs.pop_front();
				if (min_cost !== oldest_cost.min_cost)
					report_mismatch("min_cost", {25'b0, min_cost},
						{25'b0, oldest_cost.min_cost});
				if (too_short !== oldest_cost.too_short)
					report_mismatch("too_short", {63'b0, too_short},
						{63'b0, oldest_cost.too_short});
			end
		end
	end

	// The run ends here if the block hangs or never returns an owed result.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL sliding_window_k_smallest_sum_min");
			$finish;
		end
	end

	initial begin
		row_t               row;
		phase_t             phase;
		int                 remaining;
		int                 len;
		int                 w;
		int                 r;
		logic [VALUE_W-1:0] v;

		pick_q = PICK_RESET;
		span_q = SPAN_RESET;
		head_q = '0;
		best_q = '1;
		seen_q = '0;

		// Reset is applied once, at the start.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the table is walked in order with no idling on either side.
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			row = SCRIPT[i];
			if (row.kind == ROW_WRITE) begin
				item_valid <= 1'b0;
				wait_idle();
				write_register(row.reg_sel, row.data);
			end else begin
				send_item(row.data, row.last, row.typed, row.lit);
			end
		end

		// Random part. Each phase starts from an idle block with both registers written.
		// Sequences have random lengths. Some are short enough to be too short. Most fill
		// the window and slide it. A few run past the point where the item count saturates.
		// The last sequence of a phase is often cut off by the item budget and then dropped
		// by the next register write.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			phase = PHASES[p];
			item_valid <= 1'b0;
			wait_idle();
			write_register(REG_PICK_COUNT, APB_DW'(phase.pick));
			write_register(REG_SPAN, APB_DW'(phase.span));
			gap_pct = phase.gap_pct;
			stall_pct = phase.stall_pct;
			w = int'(phase.span) + 1;
			remaining = phase.items;
			while (remaining > 0) begin
				r = $urandom_range(99);
				if (r < 10)
					len = $urandom_range(3, 1);
				else if (r < 67)
					len = $urandom_range(w + 8, 2);
				else if (r < 97)
					len = $urandom_range(2 * w + 8, w);
				else
					len = $urandom_range(140, 120);
				for (int k = 0; k < len && remaining > 0; k++) begin
					// Small values give duplicates in the window. Values near the top and
					// single set or cleared bits push the sums to their extremes.
					r = $urandom_range(99);
					if (r < 55)
						v = $urandom;
					else if (r < 75)
						v = $urandom_range(15);
					else if (r < 85)
						v = 32'hFFFF_FFFF - $urandom_range(15);
					else if (r < 95)
						v = 32'h1 << $urandom_range(31);
					else
						v = ~(32'h1 << $urandom_range(31));
					send_item(v, (k == len - 1), 1'b0, '0);
					remaining--;
				end
			end
		end

		// Drain: every owed result must come back, and nothing more may follow.
		item_valid <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		wait_idle();

		if (mismatch_count == 0)
			$display("PASS sliding_window_k_smallest_sum_min");
		else
			$display("FAIL sliding_window_k_smallest_sum_min");
		$finish;
	end

endmodule

/* sliding_window_k_smallest_sum_min.f */
+incdir+design
design/swksm_pkg.sv
design/swksm_ram.sv
design/swksm_alu.sv
design/swksm_cfg.sv
design/swksm_core.sv
design/sliding_window_k_smallest_sum_min.sv
sim/tb.sv
